/* sv/bls_pkg.sv */
// shared types and constants of the line stepper
package bls_pkg;

  // coordinate width and derived widths
  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int TWICE_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int COLOR_BITS = 32;

  // depth of the queue between front and back
  localparam int Q_DEPTH    = 2;
  localparam int PTR_BITS   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(Q_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [COLOR_BITS-1:0] color_t;

  // operation codes of an input word
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  // stepping directions of a line
  typedef struct packed {
    logic incl;   // minor step also on zero error
    logic ydown;
    logic xdown;
    logic ymaj;
  } dir_t;

  // classified word held in the queue
  typedef struct packed {
    op_t    op;
    coord_t start_x;
    coord_t start_y;
    coord_t end_major;
    mag_t   major;
    mag_t   minor;
    dir_t   dir;
    color_t color;
  } entry_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // back end status
  typedef struct packed {
    logic busy;
    logic fire;
    logic last;
  } bk_stat_t;

endpackage

/* sv/bls_in_if.sv */
// input channel of the line stepper
interface bls_in_if import bls_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   operation;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  color_t line_color;

  modport source (output valid, operation, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink   (input valid, operation, x_start, y_start, x_end, y_end, line_color,
                  output ready);
endinterface

/* sv/bls_out_if.sv */
// result channel of the line stepper
interface bls_out_if import bls_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

/* sv/bls_front.sv */
// front end: accepts words and works out the line setup of a load
module bls_front import bls_pkg::*; (
  bls_in_if.sink   in_ch,
  input  q_stat_t  q_stat,
  output logic     push,
  output entry_t   entry
);

  logic signed [DELTA_BITS-1:0] dx;
  logic signed [DELTA_BITS-1:0] dy;
  logic        [DELTA_BITS-1:0] adx_w;
  logic        [DELTA_BITS-1:0] ady_w;
  mag_t                         adx;
  mag_t                         ady;
  logic                         xmaj;

  // accept whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // deltas and their magnitudes
  always_comb begin
    dx    = DELTA_BITS'(in_ch.x_end) - DELTA_BITS'(in_ch.x_start);
    dy    = DELTA_BITS'(in_ch.y_end) - DELTA_BITS'(in_ch.y_start);
    adx_w = dx[DELTA_BITS-1] ? -dx : dx;
    ady_w = dy[DELTA_BITS-1] ? -dy : dy;
    adx   = adx_w[COORD_BITS-1:0];
    ady   = ady_w[COORD_BITS-1:0];
    xmaj  = (adx >= ady);
  end

  // classified word, ties go to x
  always_comb begin
    entry.op         = op_t'(in_ch.operation);
    entry.start_x    = in_ch.x_start;
    entry.start_y    = in_ch.y_start;
    entry.end_major  = xmaj ? in_ch.x_end : in_ch.y_end;
    entry.major      = xmaj ? adx : ady;
    entry.minor      = xmaj ? ady : adx;
    entry.dir.ymaj   = !xmaj;
    entry.dir.xdown  = dx[DELTA_BITS-1];
    entry.dir.ydown  = dy[DELTA_BITS-1];
    entry.dir.incl   = dx[DELTA_BITS-1] || (dx == '0);
    entry.color      = in_ch.line_color;
  end

endmodule

/* sv/bls_queue.sv */
// short queue between front and back end
module bls_queue import bls_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  entry_t   wr_entry,
  input  logic     pop,
  output entry_t   head,
  output q_stat_t  q_stat
);

  entry_t                slot_r [Q_DEPTH];
  logic   [PTR_BITS-1:0] wr_ptr_r;
  logic   [PTR_BITS-1:0] wr_ptr_nxt;
  logic   [PTR_BITS-1:0] rd_ptr_r;
  logic   [PTR_BITS-1:0] rd_ptr_nxt;
  logic   [CNT_BITS-1:0] count_r;
  logic   [CNT_BITS-1:0] count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign q_stat.full  = (count_r == CNT_BITS'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

/* sv/bls_back.sv */
// back end: line state, error stepping and the result register
module bls_back import bls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output bk_stat_t  bk_stat,
  bls_out_if.source out_ch
);

  coord_t                       cur_x_r, cur_x_nxt;
  coord_t                       cur_y_r, cur_y_nxt;
  coord_t                       end_major_r;
  logic signed [ERR_BITS-1:0]   err_r, err_nxt;
  logic        [TWICE_BITS-1:0] twice_major_r;
  logic        [TWICE_BITS-1:0] twice_minor_r;
  dir_t                         dir_r;
  logic                         busy_r, busy_nxt;
  color_t                       color_r;

  logic                         out_valid_r, out_valid_nxt;
  coord_t                       out_x_r;
  coord_t                       out_y_r;
  color_t                       out_color_r;
  logic                         out_last_r;

  logic                         is_load;
  logic                         fire;
  logic signed [ERR_BITS-1:0]   err_sub;
  logic                         move_minor;
  coord_t                       x_step;
  coord_t                       y_step;
  logic                         last;

  // take a word when the result register is free or being drained
  assign pop     = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign is_load = (head.op == OP_LOAD);
  assign fire    = pop && !is_load && busy_r;

  // one bresenham step
  always_comb begin
    err_sub    = err_r - $signed(ERR_BITS'(twice_minor_r));
    move_minor = dir_r.incl ? (err_sub[ERR_BITS-1] || (err_sub == '0))
                            : err_sub[ERR_BITS-1];
    err_nxt    = move_minor ? err_sub + $signed(ERR_BITS'(twice_major_r)) : err_sub;
    x_step     = dir_r.xdown ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    y_step     = dir_r.ydown ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    cur_x_nxt  = (!dir_r.ymaj || move_minor) ? x_step : cur_x_r;
    cur_y_nxt  = (dir_r.ymaj || move_minor) ? y_step : cur_y_r;
    last       = dir_r.ymaj ? (y_step == end_major_r) : (x_step == end_major_r);
    busy_nxt   = busy_r;
    if (pop && is_load) begin
      busy_nxt = (head.major != '0);
    end else if (fire && last) begin
      busy_nxt = 1'b0;
    end
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (pop && is_load) begin
      cur_x_r       <= head.start_x;
      cur_y_r       <= head.start_y;
      end_major_r   <= head.end_major;
      err_r         <= $signed(ERR_BITS'(head.major));
      twice_major_r <= {head.major, 1'b0};
      twice_minor_r <= {head.minor, 1'b0};
      dir_r         <= head.dir;
      color_r       <= head.color;
    end else if (fire) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_color_r <= color_r;
      out_last_r  <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last        = out_last_r;

  assign bk_stat.busy = busy_r;
  assign bk_stat.fire = fire;
  assign bk_stat.last = last;

endmodule

/* sv/bresenham_line_stepper_unit.sv */
// Bresenham line stepper: a load word latches start, end and color of a line
// and gives no pixel; each step word then gives one pixel, last set on the
// final one before the excluded end point. Steps with no line in progress are
// dropped. One word is taken per clock while the queue has room: the front
// end works out the deltas and octant of a load in the cycle it accepts it, a
// two-entry queue holds classified words, and the back end executes one word
// per clock while its result register is free or draining (one error
// subtract, add and compare). Words are registered in the queue, pixels in
// the result register; a stalled result port backs up queue, then input ready.
module bresenham_line_stepper_unit import bls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bls_in_if.sink    in_chan,
  bls_out_if.source out_chan
);

  entry_t   wr_entry;
  entry_t   head;
  logic     push;
  logic     pop;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;

  // word classification
  bls_front u_front (
    .in_ch  (in_chan),
    .q_stat (q_stat),
    .push   (push),
    .entry  (wr_entry)
  );

  // decoupling queue
  bls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // stepping and result register
  bls_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .bk_stat (bk_stat),
    .out_ch  (out_chan)
  );

  // queue can never be both full and empty
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // a pixel is only produced for a line in progress
  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.fire |-> bk_stat.busy)
    else $error("pixel produced while idle");

  // the final pixel ends the line
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.fire && bk_stat.last) |=> !bk_stat.busy)
    else $error("line still busy after final pixel");

  // a produced pixel shows up on the result port next cycle
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.fire |=> out_chan.valid)
    else $error("produced pixel not presented");

endmodule
